>>> rtl/assert_macros.svh
// Assertion helpers for the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/ffba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants, types and command codes of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int NUM_BLOCKS = 1024;
    localparam int ADDR_W     = $clog2(NUM_BLOCKS);
    localparam int LEN_W      = 11;
    localparam int IDX_W      = LEN_W + 1;
    localparam int HDR_W      = LEN_W + 1;
    localparam int REQ_W      = 24;
    localparam int OFS_W      = 22;
    localparam int NEED_W     = 22;
    localparam int LG_W       = 4;
    localparam int FUNC_W     = 2;

    localparam logic [LG_W-1:0]  LG_MIN   = 4'd3;
    localparam logic [LG_W-1:0]  LG_MAX   = 4'd12;
    localparam logic [LG_W-1:0]  LG_RST   = 4'd5;
    localparam logic [LEN_W-1:0] BLK_RST  = LEN_W'(NUM_BLOCKS);

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic CFG_BSL2   = 1'b0;
    localparam logic CFG_USABLE = 1'b1;

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP     = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD    = 4'd1;
    localparam logic [OP_W-1:0] OP_A_RD    = 4'd2;
    localparam logic [OP_W-1:0] OP_A_HIT   = 4'd3;
    localparam logic [OP_W-1:0] OP_A_STEP  = 4'd4;
    localparam logic [OP_W-1:0] OP_A_SPLIT = 4'd5;
    localparam logic [OP_W-1:0] OP_F_RD    = 4'd6;
    localparam logic [OP_W-1:0] OP_F_MARK  = 4'd7;
    localparam logic [OP_W-1:0] OP_F_PRD   = 4'd8;
    localparam logic [OP_W-1:0] OP_F_PDEC  = 4'd9;
    localparam logic [OP_W-1:0] OP_F_PMRG  = 4'd10;
    localparam logic [OP_W-1:0] OP_F_ZCUR  = 4'd11;
    localparam logic [OP_W-1:0] OP_F_NRD   = 4'd12;
    localparam logic [OP_W-1:0] OP_F_NMRG  = 4'd13;
    localparam logic [OP_W-1:0] OP_F_NZ    = 4'd14;
    localparam logic [OP_W-1:0] OP_CLR     = 4'd15;

    typedef struct packed {
        logic             alloc;
        logic [LEN_W-1:0] len;
    } t_hdr;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            res_load;
        logic            res_ok;
    } t_cmd;

    typedef struct packed {
        logic a_end;     // walk index reached the pool end
        logic len_zero;  // read header has zero length
        logic a_hit;     // read run is free and long enough
        logic a_split;   // remainder header needed
        logic f_range;   // free block index inside the pool
        logic f_valid;   // read header starts an allocated run
        logic cur_zero;  // freed run starts at block zero
        logic p_cont;    // keep walking back
        logic p_free;    // previous run is free
        logic nx_in;     // next run index inside the pool
        logic nx_free;   // next run is free
        logic clr_last;  // last entry of the clearing sweep
    } t_stat;

endpackage

>>> rtl/ffba_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_dp
// Datapath: header memory, walk registers, config registers, result register.
// ----------------------------------------------------------------------------
module ffba_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ffba_pkg::t_cmd               i_cmd,
    output ffba_pkg::t_stat              o_stat,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [ffba_pkg::LEN_W-1:0]   i_cfg_wdata,
    input  logic [ffba_pkg::REQ_W-1:0]   i_request_bytes,
    input  logic [ffba_pkg::OFS_W-1:0]   i_free_offset,
    output logic                         o_ok,
    output logic [ffba_pkg::OFS_W-1:0]   o_alloc_offset,
    output logic [ffba_pkg::LEN_W-1:0]   o_used_blocks
);
    import ffba_pkg::*;

    logic [HDR_W-1:0]  r_mem [NUM_BLOCKS];
    logic [HDR_W-1:0]  r_rdata;
    logic [LG_W-1:0]   r_bsl2;
    logic [LEN_W-1:0]  r_usable;
    logic [NEED_W-1:0] r_need;
    logic [IDX_W-1:0]  r_idx;
    logic [LEN_W-1:0]  r_len;
    logic [ADDR_W-1:0] r_cur;
    logic              r_cur_ok;
    logic [ADDR_W-1:0] r_p;
    logic [LEN_W-1:0]  r_curlen;
    logic [ADDR_W-1:0] r_nx;
    logic [ADDR_W-1:0] r_cnt;
    logic [LEN_W-1:0]  r_used;
    logic [OFS_W-1:0]  r_ofs;
    logic              r_o_ok;
    logic [OFS_W-1:0]  r_o_ofs;
    logic [LEN_W-1:0]  r_o_used;

    logic [LG_W-1:0]   lg;
    logic [LEN_W-1:0]  n_blk;
    t_hdr              rd;
    logic [REQ_W:0]    rsum;
    logic [REQ_W:0]    nq;
    logic [OFS_W-1:0]  cur_full;
    logic [IDX_W-1:0]  a_nx;
    logic [IDX_W-1:0]  f_nx;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    t_hdr              wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;

    // clamped configuration
    always_comb begin
        if (r_bsl2 < LG_MIN) begin
            lg = LG_MIN;
        end else if (r_bsl2 > LG_MAX) begin
            lg = LG_MAX;
        end else begin
            lg = r_bsl2;
        end
        if (r_usable == '0) begin
            n_blk = LEN_W'(1);
        end else if (r_usable > BLK_RST) begin
            n_blk = BLK_RST;
        end else begin
            n_blk = r_usable;
        end
    end

    assign rd       = t_hdr'(r_rdata);
    assign rsum     = {1'b0, i_request_bytes} + (((REQ_W+1)'(1)) << lg) - (REQ_W+1)'(1);
    assign nq       = rsum >> lg;
    assign cur_full = i_free_offset >> lg;
    assign a_nx     = r_idx + IDX_W'(r_need[LEN_W-1:0]);
    assign f_nx     = IDX_W'(r_cur) + IDX_W'(r_curlen);

    always_comb begin
        o_stat.a_end    = r_idx >= IDX_W'(n_blk);
        o_stat.len_zero = rd.len == '0;
        o_stat.a_hit    = !rd.alloc && (NEED_W'(rd.len) >= r_need);
        o_stat.a_split  = (NEED_W'(rd.len) > r_need) && (a_nx < IDX_W'(n_blk));
        o_stat.f_range  = r_cur_ok;
        o_stat.f_valid  = (rd.len != '0) && rd.alloc;
        o_stat.cur_zero = r_cur == '0;
        o_stat.p_cont   = (r_p != '0) && (rd.len == '0);
        o_stat.p_free   = (rd.len != '0) && !rd.alloc;
        o_stat.nx_in    = f_nx < IDX_W'(n_blk);
        o_stat.nx_free  = (rd.len != '0) && !rd.alloc;
        o_stat.clr_last = r_cnt == ADDR_W'(NUM_BLOCKS - 1);
    end

    // memory port selection
    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        re    = 1'b0;
        raddr = '0;
        case (i_cmd.op)
            OP_A_RD: begin
                re    = 1'b1;
                raddr = r_idx[ADDR_W-1:0];
            end
            OP_A_HIT: begin
                we    = 1'b1;
                waddr = r_idx[ADDR_W-1:0];
                wdata = '{alloc: 1'b1, len: r_need[LEN_W-1:0]};
            end
            OP_A_SPLIT: begin
                we    = 1'b1;
                waddr = a_nx[ADDR_W-1:0];
                wdata = '{alloc: 1'b0, len: r_len - r_need[LEN_W-1:0]};
            end
            OP_F_RD: begin
                re    = 1'b1;
                raddr = r_cur;
            end
            OP_F_MARK: begin
                we    = 1'b1;
                waddr = r_cur;
                wdata = '{alloc: 1'b0, len: rd.len};
            end
            OP_F_PRD: begin
                re    = 1'b1;
                raddr = r_p;
            end
            OP_F_PMRG: begin
                we    = 1'b1;
                waddr = r_p;
                wdata = '{alloc: 1'b0, len: rd.len + r_curlen};
            end
            OP_F_ZCUR: begin
                we    = 1'b1;
                waddr = r_cur;
            end
            OP_F_NRD: begin
                re    = 1'b1;
                raddr = f_nx[ADDR_W-1:0];
            end
            OP_F_NMRG: begin
                we    = 1'b1;
                waddr = r_cur;
                wdata = '{alloc: 1'b0, len: r_curlen + rd.len};
            end
            OP_F_NZ: begin
                we    = 1'b1;
                waddr = r_nx;
            end
            OP_CLR: begin
                we    = 1'b1;
                waddr = r_cnt;
                wdata = '{alloc: 1'b0, len: (r_cnt == '0) ? n_blk : '0};
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= r_mem[raddr];
        end
    end

    // control-side registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bsl2   <= LG_RST;
            r_usable <= BLK_RST;
            r_cnt    <= '0;
            r_used   <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_BSL2) begin
                r_bsl2 <= i_cfg_wdata[LG_W-1:0];
            end else begin
                r_usable <= i_cfg_wdata;
            end
            r_cnt  <= '0;
            r_used <= '0;
        end else begin
            case (i_cmd.op)
                OP_A_HIT:  r_used <= r_used + r_need[LEN_W-1:0];
                OP_F_MARK: r_used <= r_used - ((rd.len <= r_used) ? rd.len : r_used);
                OP_CLR: begin
                    r_cnt  <= o_stat.clr_last ? '0 : r_cnt + ADDR_W'(1);
                    r_used <= '0;
                end
                default: r_used <= r_used;
            endcase
        end
    end

    // walk and payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_need   <= (nq == '0) ? NEED_W'(1) : nq[NEED_W-1:0];
                r_idx    <= '0;
                r_cur    <= cur_full[ADDR_W-1:0];
                r_cur_ok <= cur_full < OFS_W'(n_blk);
                r_ofs    <= '0;
            end
            OP_A_HIT: begin
                r_len <= rd.len;
                r_ofs <= OFS_W'(r_idx[ADDR_W-1:0]) << lg;
            end
            OP_A_STEP: r_idx <= r_idx + IDX_W'(rd.len);
            OP_F_MARK: begin
                r_curlen <= rd.len;
                r_p      <= r_cur - ADDR_W'(1);
            end
            OP_F_PDEC: r_p <= r_p - ADDR_W'(1);
            OP_F_PMRG: r_curlen <= rd.len + r_curlen;
            OP_F_ZCUR: r_cur <= r_p;
            OP_F_NMRG: begin
                r_curlen <= r_curlen + rd.len;
                r_nx     <= f_nx[ADDR_W-1:0];
            end
            default: r_idx <= r_idx;
        endcase
        if (i_cmd.res_load) begin
            r_o_ok   <= i_cmd.res_ok;
            r_o_ofs  <= i_cmd.res_ok ? r_ofs : '0;
            r_o_used <= r_used;
        end
    end

    assign o_ok           = r_o_ok;
    assign o_alloc_offset = r_o_ofs;
    assign o_used_blocks  = r_o_used;

endmodule

>>> rtl/ffba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer for allocate, free and clear; owns the handshake flags.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffba_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ffba_pkg::FUNC_W-1:0]   i_func,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  logic                          i_cfg_we,
    input  ffba_pkg::t_stat               i_stat,
    output ffba_pkg::t_cmd                o_cmd
);
    import ffba_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLR    = 4'd1;
    localparam logic [3:0] S_A_RD   = 4'd2;
    localparam logic [3:0] S_A_CHK  = 4'd3;
    localparam logic [3:0] S_A_SPL  = 4'd4;
    localparam logic [3:0] S_F_RD   = 4'd5;
    localparam logic [3:0] S_F_CHK  = 4'd6;
    localparam logic [3:0] S_F_PRD  = 4'd7;
    localparam logic [3:0] S_F_PCHK = 4'd8;
    localparam logic [3:0] S_F_ZCUR = 4'd9;
    localparam logic [3:0] S_F_NRD  = 4'd10;
    localparam logic [3:0] S_F_NCHK = 4'd11;
    localparam logic [3:0] S_F_NZ   = 4'd12;
    localparam logic [3:0] S_FIN    = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_ok;
    logic       n_ok;
    logic       r_clr_res;
    logic       n_clr_res;
    logic       r_out_valid;
    logic       accept;
    logic       out_free;

    assign o_in_ready = r_state == S_IDLE;
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state   = r_state;
        n_ok      = r_ok;
        n_clr_res = r_clr_res;
        o_cmd     = '{op: OP_NOP, res_load: 1'b0, res_ok: r_ok};
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.op = OP_LOAD;
                    n_ok     = 1'b0;
                    case (i_func)
                        FUNC_ALLOC: n_state = S_A_RD;
                        FUNC_FREE:  n_state = S_F_RD;
                        FUNC_CLEAR: begin
                            n_state   = S_CLR;
                            n_clr_res = 1'b1;
                            n_ok      = 1'b1;
                        end
                        default:    n_state = S_FIN;
                    endcase
                end
            end
            S_CLR: begin
                o_cmd.op = OP_CLR;
                if (i_stat.clr_last) begin
                    n_state = r_clr_res ? S_FIN : S_IDLE;
                end
            end
            S_A_RD: begin
                if (i_stat.a_end) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.op = OP_A_RD;
                    n_state  = S_A_CHK;
                end
            end
            S_A_CHK: begin
                if (i_stat.len_zero) begin
                    n_state = S_FIN;
                end else if (i_stat.a_hit) begin
                    o_cmd.op = OP_A_HIT;
                    n_ok     = 1'b1;
                    n_state  = i_stat.a_split ? S_A_SPL : S_FIN;
                end else begin
                    o_cmd.op = OP_A_STEP;
                    n_state  = S_A_RD;
                end
            end
            S_A_SPL: begin
                o_cmd.op = OP_A_SPLIT;
                n_state  = S_FIN;
            end
            S_F_RD: begin
                if (i_stat.f_range) begin
                    o_cmd.op = OP_F_RD;
                    n_state  = S_F_CHK;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_F_CHK: begin
                if (i_stat.f_valid) begin
                    o_cmd.op = OP_F_MARK;
                    n_ok     = 1'b1;
                    n_state  = i_stat.cur_zero ? S_F_NRD : S_F_PRD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_F_PRD: begin
                o_cmd.op = OP_F_PRD;
                n_state  = S_F_PCHK;
            end
            S_F_PCHK: begin
                if (i_stat.p_cont) begin
                    o_cmd.op = OP_F_PDEC;
                    n_state  = S_F_PRD;
                end else if (i_stat.p_free) begin
                    o_cmd.op = OP_F_PMRG;
                    n_state  = S_F_ZCUR;
                end else begin
                    n_state = S_F_NRD;
                end
            end
            S_F_ZCUR: begin
                o_cmd.op = OP_F_ZCUR;
                n_state  = S_F_NRD;
            end
            S_F_NRD: begin
                if (i_stat.nx_in) begin
                    o_cmd.op = OP_F_NRD;
                    n_state  = S_F_NCHK;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_F_NCHK: begin
                if (i_stat.nx_free) begin
                    o_cmd.op = OP_F_NMRG;
                    n_state  = S_F_NZ;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_F_NZ: begin
                o_cmd.op = OP_F_NZ;
                n_state  = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // a config write restarts the clearing sweep
        if (i_cfg_we) begin
            o_cmd.op       = OP_NOP;
            o_cmd.res_load = 1'b0;
            n_state        = S_CLR;
            n_clr_res      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_ok        <= 1'b0;
            r_clr_res   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ok      <= n_ok;
            r_clr_res <= n_clr_res;
            if (o_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    `ASSERT_CLK(a_load_free, i_clk, i_rst_n, o_cmd.res_load |-> (!r_out_valid || i_out_ready), "result loaded over a waiting transfer")
    `ASSERT_CLK(a_accept_busy, i_clk, i_rst_n, (accept && !i_cfg_we) |=> (r_state != S_IDLE), "accepted item left the sequencer idle")
    `ASSERT_CLK(a_fin_done, i_clk, i_rst_n, (o_cmd.res_load && !i_cfg_we) |=> (r_state == S_IDLE && r_out_valid), "result not presented after finish")

endmodule

>>> rtl/first_fit_block_allocator.sv
`timescale 1ns / 1ps
// Steps: allocate reads one run header per run stepped over, then writes a remainder
//   header when needed; free walks back to the previous run header, one memory read per
//   block; clear sweeps all N header entries (N = 1024); an unknown function just finishes.
// Throughput: one item at a time, limited by the single-port header memory walk.
// Reset: synchronous, active low; then a clearing sweep of the header memory, during
//   which no item is taken. Any config write starts the same sweep.
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit block allocator with run coalescing over a header table.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ffba_pkg::FUNC_W-1:0]   i_func,
    input  logic [ffba_pkg::REQ_W-1:0]    i_request_bytes,
    input  logic [ffba_pkg::OFS_W-1:0]    i_free_offset,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_ok,
    output logic [ffba_pkg::OFS_W-1:0]    o_alloc_offset,
    output logic [ffba_pkg::LEN_W-1:0]    o_used_blocks,
    // config write port: index 0 block_size_log2, index 1 usable_blocks
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [ffba_pkg::LEN_W-1:0]    i_cfg_wdata
);
    import ffba_pkg::*;

    // Controller steps the walk and issues one datapath command per cycle;
    // the datapath answers with header compare flags. The result register
    // in the datapath lets the next transfer be taken while one waits.
    t_cmd  cmd;
    t_stat stat;

    ffba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_we    (i_cfg_we),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ffba_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_request_bytes (i_request_bytes),
        .i_free_offset   (i_free_offset),
        .o_ok            (o_ok),
        .o_alloc_offset  (o_alloc_offset),
        .o_used_blocks   (o_used_blocks)
    );

endmodule

>>> tb/sv/tb_first_fit_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator
// Self-checking bench for the first-fit block allocator. A behavioral copy of
// the run header table predicts every result. Directed cases come first, then
// random phases under several block sizes and pool sizes, with random gaps on
// the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator;
    import ffba_pkg::*;

    // function code with no operation behind it
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        logic             ok;
        logic [OFS_W-1:0] offset;
        logic [LEN_W-1:0] used;
    } t_alloc_result;

    // Behavioral header table plus the queue of predicted results.
    class alloc_table_model;
        int unsigned   run_len [NUM_BLOCKS];
        bit            run_busy [NUM_BLOCKS];
        int unsigned   used_count;
        int unsigned   size_log2;
        int unsigned   pool_blocks;
        t_alloc_result expected_results[$];
        int            errors;

        function new();
            size_log2   = LG_RST;
            pool_blocks = NUM_BLOCKS;
            errors      = 0;
            reset_table();
        endfunction

        function int unsigned lg_eff();
            if (size_log2 < LG_MIN) return LG_MIN;
            if (size_log2 > LG_MAX) return LG_MAX;
            return size_log2;
        endfunction

        function int unsigned blocks_eff();
            if (pool_blocks < 1) return 1;
            if (pool_blocks > NUM_BLOCKS) return NUM_BLOCKS;
            return pool_blocks;
        endfunction

        function void reset_table();
            foreach (run_len[i]) begin
                run_len[i]  = 0;
                run_busy[i] = 0;
            end
            run_len[0] = blocks_eff();
            used_count = 0;
        endfunction

        // any config write also wipes the pool
        function void configure(logic idx, logic [LEN_W-1:0] data);
            if (idx == CFG_BSL2) size_log2 = data[3:0];
            else                 pool_blocks = data;
            reset_table();
        endfunction

        function bit try_alloc(int unsigned req, output int unsigned ofs);
            int unsigned lg, n, need, idx, len;
            lg   = lg_eff();
            n    = blocks_eff();
            need = (req + (1 << lg) - 1) >> lg;
            idx  = 0;
            ofs  = 0;
            if (need == 0) need = 1;
            while (idx < n) begin
                len = run_len[idx];
                if (len == 0) return 0;
                if (!run_busy[idx] && len >= need) begin
                    run_len[idx]  = need;
                    run_busy[idx] = 1;
                    // exact fit leaves the following header alone
                    if (len > need && idx + need < n) begin
                        run_len[idx + need]  = len - need;
                        run_busy[idx + need] = 0;
                    end
                    used_count += need;
                    ofs = (idx << lg) & 32'h3FFFFF;
                    return 1;
                end
                idx += len;
            end
            return 0;
        endfunction

        function bit try_free(int unsigned offset);
            int unsigned n, cur, p, nx;
            n   = blocks_eff();
            cur = offset >> lg_eff();
            if (cur >= n) return 0;
            if (run_len[cur] == 0 || !run_busy[cur]) return 0;
            used_count -= (run_len[cur] <= used_count) ? run_len[cur] : used_count;
            run_busy[cur] = 0;
            if (cur > 0) begin
                p = cur - 1;
                while (p > 0 && run_len[p] == 0) p--;
                if (run_len[p] != 0 && !run_busy[p]) begin
                    run_len[p]  += run_len[cur];
                    run_len[cur] = 0;
                    cur = p;
                end
            end
            nx = cur + run_len[cur];
            if (nx < n && run_len[nx] != 0 && !run_busy[nx]) begin
                run_len[cur] += run_len[nx];
                run_len[nx]   = 0;
            end
            return 1;
        endfunction

        function void note_request(logic [FUNC_W-1:0] func, logic [REQ_W-1:0] req,
                                   logic [OFS_W-1:0] fofs);
            t_alloc_result r;
            int unsigned   ofs;
            ofs = 0;
            r.ok = 0;
            if (func == FUNC_ALLOC) begin
                r.ok = try_alloc(req, ofs);
            end else if (func == FUNC_FREE) begin
                r.ok = try_free(fofs);
            end else if (func == FUNC_CLEAR) begin
                reset_table();
                r.ok = 1;
            end
            r.offset = ofs[OFS_W-1:0];
            r.used   = used_count[LEN_W-1:0];
            expected_results.push_back(r);
        endfunction

        // random start offset of an allocated run, -1 if none
        function int pick_busy_offset();
            int unsigned starts[$];
            int unsigned idx;
            idx = 0;
            while (idx < blocks_eff() && run_len[idx] != 0) begin
                if (run_busy[idx]) starts.push_back(idx);
                idx += run_len[idx];
            end
            if (starts.size() == 0) return -1;
            return starts[$urandom_range(starts.size() - 1)] << lg_eff();
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            if (errors <= 40)
                $display("[%0t] mismatch %s: got %0d want %0d", $time, what, got, want);
        endtask

        task check_result(logic ok, logic [OFS_W-1:0] offset, logic [LEN_W-1:0] used);
            t_alloc_result e;
            if (expected_results.size() == 0) begin
                report("unexpected result transfer", 1, 0);
                return;
            end
            e = expected_results.pop_front();
            if (ok !== e.ok)         report("ok", ok, e.ok);
            if (offset !== e.offset) report("alloc_offset", offset, e.offset);
            if (used !== e.used)     report("used_blocks", used, e.used);
        endtask
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    logic [FUNC_W-1:0] i_func;
    logic [REQ_W-1:0] i_request_bytes;
    logic [OFS_W-1:0] i_free_offset;
    logic             o_out_valid;
    logic             i_out_ready;
    logic             o_ok;
    logic [OFS_W-1:0] o_alloc_offset;
    logic [LEN_W-1:0] o_used_blocks;
    logic             i_cfg_we;
    logic             i_cfg_idx;
    logic [LEN_W-1:0] i_cfg_wdata;

    alloc_table_model table_model;
    int               hold_requests = 0;   // bumped by the sender to ask for a long stall
    int               items_sent    = 0;

    first_fit_block_allocator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_request_bytes (i_request_bytes),
        .i_free_offset   (i_free_offset),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_ok            (o_ok),
        .o_alloc_offset  (o_alloc_offset),
        .o_used_blocks   (o_used_blocks),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop; the slowest legal run is far below this.
    initial begin
        #40ms;
        $display("Simulation FAILED");
        $finish;
    end

    // Result side: runs in randomly chosen stall modes. A hold
    // request from the sender forces a long stall so the block backs up.
    always @(negedge i_clk) begin : result_sink
        static int hold_left = 0;
        static int seen_holds = 0;
        static int mode_left = 0;
        static int mode = 0;
        if (hold_requests != seen_holds) begin
            seen_holds = hold_requests;
            hold_left  = 3000;
        end
        if (mode_left == 0) begin
            mode      = $urandom_range(3);
            mode_left = $urandom_range(50, 400);
        end
        mode_left--;
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            case (mode)
                0: i_out_ready <= 1'b1;                       // no stalls
                1: i_out_ready <= $urandom_range(1);
                2: i_out_ready <= ($urandom_range(3) != 0);
                default: i_out_ready <= ($urandom_range(7) == 0);
            endcase
        end
    end

    // Result monitor, sampled on the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            table_model.check_result(o_ok, o_alloc_offset, o_used_blocks);
    end

    // Present one item and hold it until the transfer. Valid stays high on
    // return so back-to-back items never drop it.
    task automatic send_item(logic [FUNC_W-1:0] func, logic [REQ_W-1:0] req,
                             logic [OFS_W-1:0] fofs);
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_func          <= func;
        i_request_bytes <= req;
        i_free_offset   <= fofs;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        table_model.note_request(func, req, fofs);
        items_sent++;
    endtask

    task automatic idle_input(int cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic drain_results();
        idle_input(0);
        while (table_model.expected_results.size() != 0) @(negedge i_clk);
    endtask

    // Written only with nothing in flight; each write also starts a pool sweep.
    task automatic write_reg(logic idx, logic [LEN_W-1:0] data);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        table_model.configure(idx, data);
    endtask

    // One random item: mostly allocate/free traffic over live runs.
    task automatic send_random_item();
        int unsigned lg, pick, nblk, req, busy;
        int          ofs;
        lg   = table_model.lg_eff();
        pick = $urandom_range(99);
        if (pick < 46) begin
            nblk = $urandom_range(99);
            if (nblk < 70)      nblk = $urandom_range(1, 4);
            else if (nblk < 90) nblk = $urandom_range(1, 32);
            else                nblk = $urandom_range(1, table_model.blocks_eff());
            req = (nblk << lg) - $urandom_range((1 << lg) - 1);
            if ($urandom_range(49) == 0) req = $urandom_range(24'hFFFFFF);
            send_item(FUNC_ALLOC, req[REQ_W-1:0], OFS_W'($urandom));
        end else if (pick < 86) begin
            ofs = table_model.pick_busy_offset();
            if (ofs < 0) ofs = 0;
            // sometimes point inside the block to exercise truncation
            if ($urandom_range(3) == 0) ofs += $urandom_range((1 << lg) - 1);
            send_item(FUNC_FREE, REQ_W'($urandom), ofs[OFS_W-1:0]);
        end else if (pick < 94) begin
            busy = $urandom_range(1);
            ofs  = busy ? $urandom_range(22'h3FFFFF)
                        : $urandom_range(table_model.blocks_eff() - 1) << lg;
            send_item(FUNC_FREE, REQ_W'($urandom), ofs[OFS_W-1:0]);
        end else if (pick < 97) begin
            send_item(FUNC_CLEAR, REQ_W'($urandom), OFS_W'($urandom));
        end else begin
            send_item(FUNC_UNUSED, REQ_W'($urandom), OFS_W'($urandom));
        end
    endtask

    task automatic random_phase(int count, bit with_pressure);
        int burst;
        burst = 0;
        for (int k = 0; k < count; k++) begin
            if (with_pressure && k == count / 3) begin
                // long result stall while items keep coming
                hold_requests++;
                for (int j = 0; j < 12; j++) send_random_item();
            end
            if (with_pressure && k == 2 * count / 3)
                drain_results();        // sender waits for every result
            if (burst == 0) begin
                burst = $urandom_range(1, 30);
                if ($urandom_range(3) != 0) idle_input($urandom_range(1, 20));
            end
            burst--;
            send_random_item();
        end
    endtask

    initial begin
        logic [LEN_W-1:0] phase_lg [7];
        logic [LEN_W-1:0] phase_blocks [7];
        table_model     = new();
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_func          = FUNC_ALLOC;
        i_request_bytes = '0;
        i_free_offset   = '0;
        i_out_ready     = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_BSL2;
        i_cfg_wdata     = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset config, 32-byte blocks over 1024 blocks.
        send_item(FUNC_ALLOC, 24'd0, 22'd0);           // zero bytes still takes a block
        send_item(FUNC_ALLOC, 24'd1, 22'd0);
        send_item(FUNC_ALLOC, 24'd33, 22'd0);          // rounds up to two blocks
        send_item(FUNC_ALLOC, 24'hFFFFFF, 22'h3FFFFF); // too big, no fit
        send_item(FUNC_FREE, 24'd0, 22'd37);           // misaligned, truncated to block 1
        send_item(FUNC_FREE, 24'd0, 22'd32);           // already free
        send_item(FUNC_FREE, 24'd0, 22'd96);           // inside a run
        send_item(FUNC_FREE, 24'hFFFFFF, 22'h3FFFFF);  // beyond the pool
        send_item(FUNC_ALLOC, 24'd32, 22'd0);          // reuses the freed hole exactly
        send_item(FUNC_FREE, 24'd0, 22'd0);            // merges with nothing before
        send_item(FUNC_FREE, 24'd0, 22'd64);           // merges only with the free run after it
        send_item(FUNC_FREE, 24'd0, 22'd32);           // coalesces into the head run
        send_item(FUNC_UNUSED, 24'hFFFFFF, 22'h3FFFFF); // unknown function
        send_item(FUNC_ALLOC, 24'd32768, 22'd0);       // whole pool, exact fit
        send_item(FUNC_ALLOC, 24'd1, 22'd0);           // pool full
        send_item(FUNC_CLEAR, 24'd0, 22'd0);
        send_item(FUNC_ALLOC, 24'd32736, 22'd0);       // all but the last block
        send_item(FUNC_ALLOC, 24'd32, 22'd0);
        send_item(FUNC_FREE, 24'd0, 22'd0);
        send_item(FUNC_CLEAR, 24'd0, 22'd0);

        // Phases: clamped extremes, both bounds, and a few ordinary sizes.
        phase_lg     = '{11'd5, 11'd3, 11'd12, 11'd0, 11'd2047, 11'd7, 11'd4};
        phase_blocks = '{11'd1024, 11'd1, 11'd1024, 11'd0, 11'd2047, 11'd64, 11'd200};
        for (int p = 0; p < 7; p++) begin
            if (p != 0) begin
                write_reg(CFG_BSL2, phase_lg[p]);
                write_reg(CFG_USABLE, phase_blocks[p]);
            end
            random_phase(118, p == 0 || p == 5);
        end

        drain_results();
        repeat (2200) @(negedge i_clk);
        if (table_model.errors == 0 && table_model.expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
